// File: hw/rtl/cbpg_pkg.sv
package cbpg_pkg;

  localparam int DIM_W      = 12;  // coordinates, ramp steps and interval lengths
  localparam int CFG_W      = 13;  // frame size registers
  localparam int LVL_W      = 8;   // channel level
  localparam int DIV_STG    = LVL_W;  // one quotient bit per divider stage
  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;
  localparam int RST_WIDTH  = 640;
  localparam int RST_HEIGHT = 640;

  // w/7 as (w * 2341) >> 14, exact for w below 5461
  localparam int DIV7_MUL   = 2341;
  localparam int DIV7_SHIFT = 14;

  localparam logic [LVL_W-1:0] LEVEL_MAX = '1;

  // bar number bits that switch the channels on
  localparam int BAR_RED_BIT   = 0;
  localparam int BAR_BLUE_BIT  = 1;
  localparam int BAR_GREEN_BIT = 2;

  // pipeline: input, three prep stages, divider stages, output
  localparam int STG_DIV0 = 4;
  localparam int NUM_STG  = STG_DIV0 + DIV_STG + 1;
  localparam int STG_OUT  = NUM_STG - 1;

  typedef enum logic [1:0] {
    CFG_PATTERN = 2'd0,
    CFG_WIDTH   = 2'd1,
    CFG_HEIGHT  = 2'd2
  } cfg_idx_e;

  // frame geometry, recomputed from the registers in the cycle after a write
  typedef struct packed {
    logic             pat;
    logic [CFG_W-1:0] w;
    logic [CFG_W-1:0] h;
    logic [DIM_W-1:0] n;
    logic [DIM_W-1:0] n2;
    logic [DIM_W-1:0] n3;
    logic [DIM_W-1:0] m;
    logic [CFG_W-1:0] m2;
    logic [DIM_W-1:0] n7;
    logic [DIM_W-1:0] n7x2;
    logic [DIM_W-1:0] n7x4;
    logic [CFG_W-1:0] n7x7;
    logic [DIM_W-1:0] d_col;
  } derived_t;

  typedef struct packed {
    logic       outside;
    logic       red_on;
    logic       blue_on;
    logic       white;
    logic [2:0] quo;
  } side_t;

  typedef struct packed {
    side_t            side;
    logic [DIM_W-1:0] gk;
    logic [DIM_W-1:0] rk;
    logic [DIM_W-1:0] rem;
  } prep_t;

  function automatic derived_t cbpg_derive(logic pat, logic [CFG_W-1:0] fw,
                                           logic [CFG_W-1:0] fh);
    derived_t               d;
    logic [CFG_W-1:0]       w;
    logic [CFG_W-1:0]       h;
    logic [CFG_W+DIM_W-1:0] prod;
    logic [DIM_W-1:0]       n;
    logic [DIM_W-1:0]       m;
    logic [DIM_W-1:0]       n7;
    w    = (fw > CFG_W'(MAX_WIDTH))  ? CFG_W'(MAX_WIDTH)  : fw;
    h    = (fh > CFG_W'(MAX_HEIGHT)) ? CFG_W'(MAX_HEIGHT) : fh;
    n    = DIM_W'(w >> 2);
    m    = DIM_W'(h >> 1);
    prod = (CFG_W+DIM_W)'(w) * (CFG_W+DIM_W)'(DIV7_MUL);
    n7   = DIM_W'(prod >> DIV7_SHIFT);
    if (n == '0) begin
      n = DIM_W'(1);
    end
    if (m == '0) begin
      m = DIM_W'(1);
    end
    if (n7 == '0) begin
      n7 = DIM_W'(1);
    end
    d.pat   = pat;
    d.w     = w;
    d.h     = h;
    d.n     = n;
    d.n2    = n << 1;
    d.n3    = (n << 1) + n;
    d.m     = m;
    d.m2    = {m, 1'b0};
    d.n7    = n7;
    d.n7x2  = n7 << 1;
    d.n7x4  = n7 << 2;
    d.n7x7  = CFG_W'({n7, 3'b000} - {3'b000, n7});
    d.d_col = pat ? n7 : n;
    return d;
  endfunction

endpackage

// File: hw/rtl/cbpg_ramp_div.sv
// Pipelined ramp level: floor(k*256/d), saturated to the top level.
// One restoring step per stage; d is held static by the frame registers.
module cbpg_ramp_div (
  input  logic                         clk_i,
  input  logic [cbpg_pkg::DIV_STG-1:0] en_i,
  input  logic [cbpg_pkg::DIM_W-1:0]   k_i,
  input  logic [cbpg_pkg::DIM_W-1:0]   d_i,
  output logic [cbpg_pkg::LVL_W-1:0]   level_o
);
  import cbpg_pkg::*;

  logic [DIM_W-1:0] rem_q [DIV_STG];
  logic [LVL_W-1:0] quo_q [DIV_STG];
  logic             sat_q [DIV_STG];

  for (genvar j = 0; j < DIV_STG; j++) begin : g_stg
    logic [DIM_W-1:0] rem_in;
    logic [LVL_W-1:0] quo_in;
    logic             sat_in;
    logic [DIM_W:0]   dbl;
    logic             ge;
    logic [DIM_W-1:0] rem_d;
    logic [LVL_W-1:0] quo_d;

    if (j == 0) begin : g_first
      // k >= d means the level reaches 256 or more
      assign rem_in = k_i;
      assign quo_in = '0;
      assign sat_in = (k_i >= d_i);
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign quo_in = quo_q[j-1];
      assign sat_in = sat_q[j-1];
    end

    always_comb begin
      dbl   = {rem_in, 1'b0};
      ge    = (dbl >= {1'b0, d_i});
      rem_d = ge ? DIM_W'(dbl - {1'b0, d_i}) : DIM_W'(dbl);
      quo_d = {quo_in[LVL_W-2:0], ge};
    end

    always_ff @(posedge clk_i) begin
      if (en_i[j]) begin
        rem_q[j] <= rem_d;
        quo_q[j] <= quo_d;
        sat_q[j] <= sat_in;
      end
    end
  end

  assign level_o = sat_q[DIV_STG-1] ? LEVEL_MAX : quo_q[DIV_STG-1];

endmodule

// File: hw/rtl/color_bar_pattern_generator_top.sv
// Test pattern source: one pixel coordinate in, that pixel's red, blue and
// green levels out, one pixel per clock sustained while the output side
// keeps up. Pattern 0 is the gradient (red/blue over four column intervals,
// green up then down over the rows), pattern 1 the seven ramped color bars
// with white past the last bar. The path is 13 register stages deep: input
// register, three prep stages (interval select and the three bar-number
// steps of column / (width/7)), eight divider stages that each produce one
// bit of floor(k*256/d), and the output register. Throughput is one pixel
// per cycle whenever the output side keeps up. Stages collapse bubbles, so
// a request is still taken while a result waits as long as some stage is
// empty. Register writes are registered, and the frame geometry derived
// from them (interval lengths, bar width) is registered in the cycle after;
// write only while no pixel is in flight. Coordinates outside the frame
// return zero levels with tuser set. Frame sizes above 4096 saturate.
module color_bar_pattern_generator_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // config write port
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_index_i,
  input  logic [cbpg_pkg::CFG_W-1:0] cfg_data_i,
  // coordinate requests
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [23:0]                s_axis_tdata,  // column[11:0], row[23:12]
  // pixel results
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [23:0]                m_axis_tdata,  // red[7:0], blue[15:8], green[23:16]
  output logic                       m_axis_tuser   // outside_frame
);
  import cbpg_pkg::*;

  // ---------------------------------------------------------------- config
  logic             pattern_q;
  logic [CFG_W-1:0] width_q;
  logic [CFG_W-1:0] height_q;
  derived_t         dv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= 1'b0;
      width_q   <= CFG_W'(RST_WIDTH);
      height_q  <= CFG_W'(RST_HEIGHT);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_PATTERN: pattern_q <= cfg_data_i[0];
        CFG_WIDTH:   width_q   <= cfg_data_i;
        CFG_HEIGHT:  height_q  <= cfg_data_i;
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q <= cbpg_derive(1'b0, CFG_W'(RST_WIDTH), CFG_W'(RST_HEIGHT));
    end else begin
      dv_q <= cbpg_derive(pattern_q, width_q, height_q);
    end
  end

  // ------------------------------------------------------ pipeline control
  logic [NUM_STG-1:0] stg_v_q;
  logic [NUM_STG-1:0] stg_v_d;
  logic [NUM_STG-1:0] stg_rdy;

  // a stage loads when it is empty or its content moves on
  assign stg_rdy[STG_OUT] = !stg_v_q[STG_OUT] || m_axis_tready;
  for (genvar k = 0; k < STG_OUT; k++) begin : g_rdy
    assign stg_rdy[k] = !stg_v_q[k] || stg_rdy[k+1];
  end

  assign stg_v_d[0] = stg_rdy[0] ? s_axis_tvalid : stg_v_q[0];
  for (genvar k = 1; k < NUM_STG; k++) begin : g_vld
    assign stg_v_d[k] = stg_rdy[k] ? stg_v_q[k-1] : stg_v_q[k];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_v_q <= '0;
    end else begin
      stg_v_q <= stg_v_d;
    end
  end

  assign s_axis_tready = stg_rdy[0];
  assign m_axis_tvalid = stg_v_q[STG_OUT];

  // ------------------------------------------------------- input register
  logic [DIM_W-1:0] col0_q;
  logic [DIM_W-1:0] row0_q;

  always_ff @(posedge clk_i) begin
    if (stg_rdy[0]) begin
      col0_q <= s_axis_tdata[DIM_W-1:0];
      row0_q <= s_axis_tdata[2*DIM_W-1:DIM_W];
    end
  end

  // ------------------------------------------------- prep 1: intervals
  prep_t p1_d;
  prep_t p1_q;
  prep_t p2_d;
  prep_t p2_q;
  prep_t p3_d;
  prep_t p3_q;

  always_comb begin
    p1_d = '0;
    p1_d.side.outside = ({1'b0, col0_q} >= dv_q.w) || ({1'b0, row0_q} >= dv_q.h);

    // gradient column step and channel enables
    if (col0_q <= dv_q.n) begin
      p1_d.gk = dv_q.n - col0_q;
      p1_d.side.red_on  = 1'b1;
      p1_d.side.blue_on = 1'b0;
    end else if (col0_q <= dv_q.n2) begin
      p1_d.gk = col0_q - dv_q.n;
      p1_d.side.red_on  = 1'b1;
      p1_d.side.blue_on = 1'b1;
    end else if (col0_q <= dv_q.n3) begin
      p1_d.gk = dv_q.n3 - col0_q;
      p1_d.side.red_on  = 1'b1;
      p1_d.side.blue_on = 1'b1;
    end else begin
      p1_d.gk = col0_q - dv_q.n3;
      p1_d.side.red_on  = 1'b0;
      p1_d.side.blue_on = 1'b1;
    end

    // green: up to m, then back down; negative steps clamp to zero
    if (row0_q <= dv_q.m) begin
      p1_d.rk = row0_q;
    end else if ({1'b0, row0_q} >= dv_q.m2) begin
      p1_d.rk = '0;
    end else begin
      p1_d.rk = DIM_W'(dv_q.m2 - {1'b0, row0_q});
    end

    // bars: past the seventh bar is white, then quotient bit 2
    p1_d.side.white = ({1'b0, col0_q} >= dv_q.n7x7);
    p1_d.side.quo[2] = (col0_q >= dv_q.n7x4);
    p1_d.rem = p1_d.side.quo[2] ? (col0_q - dv_q.n7x4) : col0_q;
  end

  // ----------------------------------------------- prep 2 / 3: bar bits
  always_comb begin
    p2_d = p1_q;
    p2_d.side.quo[1] = (p1_q.rem >= dv_q.n7x2);
    p2_d.rem = p2_d.side.quo[1] ? (p1_q.rem - dv_q.n7x2) : p1_q.rem;
  end

  always_comb begin
    p3_d = p2_q;
    p3_d.side.quo[0] = (p2_q.rem >= dv_q.n7);
    p3_d.rem = p3_d.side.quo[0] ? (p2_q.rem - dv_q.n7) : p2_q.rem;
  end

  always_ff @(posedge clk_i) begin
    if (stg_rdy[1]) begin
      p1_q <= p1_d;
    end
    if (stg_rdy[2]) begin
      p2_q <= p2_d;
    end
    if (stg_rdy[3]) begin
      p3_q <= p3_d;
    end
  end

  // -------------------------------------------------------- ramp dividers
  logic [DIM_W-1:0] col_k;
  logic [LVL_W-1:0] col_lvl;
  logic [LVL_W-1:0] row_lvl;

  // column lane: gradient step over n, or the in-bar offset over width/7
  assign col_k = dv_q.pat ? p3_q.rem : p3_q.gk;

  cbpg_ramp_div u_col_div (
    .clk_i   (clk_i),
    .en_i    (stg_rdy[STG_OUT-1:STG_DIV0]),
    .k_i     (col_k),
    .d_i     (dv_q.d_col),
    .level_o (col_lvl)
  );

  cbpg_ramp_div u_row_div (
    .clk_i   (clk_i),
    .en_i    (stg_rdy[STG_OUT-1:STG_DIV0]),
    .k_i     (p3_q.rk),
    .d_i     (dv_q.m),
    .level_o (row_lvl)
  );

  // flags ride alongside the divider stages
  side_t side_q [DIV_STG];

  for (genvar j = 0; j < DIV_STG; j++) begin : g_side
    always_ff @(posedge clk_i) begin
      if (stg_rdy[STG_DIV0+j]) begin
        side_q[j] <= (j == 0) ? p3_q.side : side_q[(j == 0) ? 0 : j-1];
      end
    end
  end

  // ------------------------------------------------------- output register
  side_t            sd;
  logic [2:0]       bar;
  logic [LVL_W-1:0] red_d;
  logic [LVL_W-1:0] blue_d;
  logic [LVL_W-1:0] green_d;
  logic [LVL_W-1:0] red_q;
  logic [LVL_W-1:0] blue_q;
  logic [LVL_W-1:0] green_q;
  logic             outside_q;

  always_comb begin
    sd  = side_q[DIV_STG-1];
    bar = sd.quo + 3'd1;
    if (sd.outside) begin
      red_d   = '0;
      blue_d  = '0;
      green_d = '0;
    end else if (!dv_q.pat) begin
      red_d   = sd.red_on  ? col_lvl : '0;
      blue_d  = sd.blue_on ? col_lvl : '0;
      green_d = row_lvl;
    end else if (sd.white) begin
      red_d   = LEVEL_MAX;
      blue_d  = LEVEL_MAX;
      green_d = LEVEL_MAX;
    end else begin
      red_d   = bar[BAR_RED_BIT]   ? col_lvl : '0;
      blue_d  = bar[BAR_BLUE_BIT]  ? col_lvl : '0;
      green_d = bar[BAR_GREEN_BIT] ? col_lvl : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stg_rdy[STG_OUT]) begin
      red_q     <= red_d;
      blue_q    <= blue_d;
      green_q   <= green_d;
      outside_q <= sd.outside;
    end
  end

  assign m_axis_tdata = {green_q, blue_q, red_q};
  assign m_axis_tuser = outside_q;

  // ------------------------------------------------------------ assertions
  a_outside_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("outside pixel with nonzero level");

  a_grad_red_blue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser && !dv_q.pat |->
      (red_q == blue_q) || (red_q == '0) || (blue_q == '0))
    else $error("gradient red and blue disagree");

  a_ready_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> stg_v_q[0] && stg_v_q[STG_OUT])
    else $error("request refused with room in the pipeline");

  a_out_from_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(stg_v_q[STG_OUT-1]))
    else $error("result appeared without a pixel in the last divider stage");

endmodule

// File: dv/cbpg_pixel_checker.sv
module cbpg_pixel_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_index_i,
  input  logic [cbpg_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                       s_axis_tvalid,
  input  logic                       s_axis_tready,
  input  logic [23:0]                s_axis_tdata,
  input  logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  input  logic [23:0]                m_axis_tdata,
  input  logic                       m_axis_tuser,
  output int                         pending_o,
  output int                         fail_count_o
);

  timeunit 1ns;
  timeprecision 1ps;

  import cbpg_pkg::*;

  // same bit order as {tuser, tdata}
  typedef struct packed {
    logic             outside;
    logic [LVL_W-1:0] green;
    logic [LVL_W-1:0] blue;
    logic [LVL_W-1:0] red;
  } pixel_t;

  logic             bars_sel;
  logic [CFG_W-1:0] width_cfg;
  logic [CFG_W-1:0] height_cfg;
  pixel_t           expected_pixels[$];

  // floor(k*256/d), clamped to 0..255
  function automatic logic [LVL_W-1:0] ramp(int k, int d);
    int v;
    if (k <= 0) begin
      return '0;
    end
    v = (k * 256) / d;
    return (v > int'(LEVEL_MAX)) ? LEVEL_MAX : LVL_W'(v);
  endfunction

  function automatic pixel_t predict_pixel(int col, int row);
    pixel_t px;
    int     w;
    int     h;
    int     n;
    int     m;
    int     n7;
    int     bar;
    logic [LVL_W-1:0] lvl;
    px = '0;
    w  = (width_cfg > CFG_W'(MAX_WIDTH)) ? MAX_WIDTH : int'(width_cfg);
    h  = (height_cfg > CFG_W'(MAX_HEIGHT)) ? MAX_HEIGHT : int'(height_cfg);
    if (col >= w || row >= h) begin
      px.outside = 1'b1;
      return px;
    end
    if (!bars_sel) begin
      n = (w / 4 == 0) ? 1 : w / 4;
      m = (h / 2 == 0) ? 1 : h / 2;
      if (col <= n) begin
        px.red = ramp(n - col, n);
      end else if (col <= 2 * n) begin
        px.red  = ramp(col - n, n);
        px.blue = px.red;
      end else if (col <= 3 * n) begin
        px.red  = ramp(3 * n - col, n);
        px.blue = px.red;
      end else begin
        px.blue = ramp(col - 3 * n, n);
      end
      px.green = (row <= m) ? ramp(row, m) : ramp(2 * m - row, m);
    end else begin
      n7  = (w / 7 == 0) ? 1 : w / 7;
      bar = col / n7 + 1;
      if (bar > 7) begin
        px.red   = LEVEL_MAX;
        px.blue  = LEVEL_MAX;
        px.green = LEVEL_MAX;
      end else begin
        lvl      = ramp(col % n7, n7);
        px.red   = bar[BAR_RED_BIT]   ? lvl : '0;
        px.blue  = bar[BAR_BLUE_BIT]  ? lvl : '0;
        px.green = bar[BAR_GREEN_BIT] ? lvl : '0;
      end
    end
    return px;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_t want;
    pixel_t got;
    if (!rst_ni) begin
      bars_sel     = 1'b0;
      width_cfg    = CFG_W'(RST_WIDTH);
      height_cfg   = CFG_W'(RST_HEIGHT);
      fail_count_o = 0;
      expected_pixels.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_PATTERN: bars_sel   = cfg_data_i[0];
          CFG_WIDTH:   width_cfg  = cfg_data_i;
          CFG_HEIGHT:  height_cfg = cfg_data_i;
          default: ;  // unmapped index, no effect
        endcase
      end
      // result side first so a same-edge request can never satisfy itself
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tuser, m_axis_tdata};
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected pixel, expected none, actual r=%0d b=%0d g=%0d out=%0b",
                   $time, got.red, got.blue, got.green, got.outside);
          fail_count_o++;
        end else begin
          want = expected_pixels.pop_front();
          if (got !== want) begin
            $display({"%0t: pixel mismatch, expected r=%0d b=%0d g=%0d out=%0b,",
                      " actual r=%0d b=%0d g=%0d out=%0b"},
                     $time, want.red, want.blue, want.green, want.outside,
                     got.red, got.blue, got.green, got.outside);
            fail_count_o++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_pixels.push_back(predict_pixel(int'(s_axis_tdata[11:0]),
                                                int'(s_axis_tdata[23:12])));
      end
    end
    pending_o = expected_pixels.size();
  end

endmodule

// File: dv/tb.sv
module tb;

  timeunit 1ns;
  timeprecision 1ps;

  import cbpg_pkg::*;

  // pattern register values and the one index the block does not map
  localparam logic       PAT_GRADIENT = 1'b0;
  localparam logic       PAT_BARS     = 1'b1;
  localparam logic [1:0] CFG_UNUSED   = 2'd3;

  // 13-stage path; a little extra before touching the registers
  localparam int DRAIN_CYCLES = 16;

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             cfg_we_i      = 1'b0;
  logic [1:0]       cfg_index_i   = '0;
  logic [CFG_W-1:0] cfg_data_i    = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [23:0]      s_axis_tdata  = '0;  // column[11:0], row[23:12]
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [23:0]      m_axis_tdata;        // red[7:0], blue[15:8], green[23:16]
  logic             m_axis_tuser;        // outside_frame

  // set for one frame: no gaps from either side
  logic no_stall = 1'b0;

  int pending;
  int fail_count;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  color_bar_pattern_generator_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  cbpg_pixel_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .pending_o     (pending),
    .fail_count_o  (fail_count)
  );

  // result side back-pressure: ~10% stall cycles unless the steady frame runs
  always @(posedge clk_i) begin
    m_axis_tready <= no_stall || ($urandom_range(99) >= 10);
  end

  // One coordinate request. Random gaps go in front of it; tvalid then holds
  // until the edge where tready is seen high. tvalid is left high afterwards
  // so back-to-back requests never lower and raise it in one step.
  task automatic send_pixel(input int col, input int row);
    while (!no_stall && $urandom_range(99) < 10) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {DIM_W'(row), DIM_W'(col)};
    do begin
      @(posedge clk_i);
    end while (!s_axis_tready);
  endtask

  // Let the pipe empty: every expected pixel back, then the path depth on top
  // so nothing is in flight when the geometry changes. The count is read off
  // the falling edge so the checker has already logged the last request.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write all three registers back to back with the enable held high; the
  // pattern write carries random junk above bit 0. Optionally a write to the
  // unmapped index follows, which must change nothing.
  task automatic load_frame(input logic pat, input int w, input int h,
                            input bit poke_unused);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_PATTERN;
    cfg_data_i  <= {12'($urandom), pat};
    @(posedge clk_i);
    cfg_index_i <= CFG_WIDTH;
    cfg_data_i  <= CFG_W'(w);
    @(posedge clk_i);
    cfg_index_i <= CFG_HEIGHT;
    cfg_data_i  <= CFG_W'(h);
    @(posedge clk_i);
    if (poke_unused) begin
      cfg_index_i <= CFG_UNUSED;
      cfg_data_i  <= CFG_W'($urandom);
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  // Random coordinate for a frame of w x h (as written, before saturation):
  // mostly inside the frame, a good share on interval and bar edges +-1,
  // and some anywhere in the 12-bit space so outside hits show up.
  task automatic send_random_pixel(input int w, input int h);
    int ew;
    int eh;
    int d;
    int col;
    int row;
    int pick;
    ew   = (w > MAX_WIDTH) ? MAX_WIDTH : w;
    eh   = (h > MAX_HEIGHT) ? MAX_HEIGHT : h;
    pick = $urandom_range(99);
    if (pick < 15 || ew == 0 || eh == 0) begin
      col = $urandom_range(4095);
      row = $urandom_range(4095);
    end else if (pick < 40) begin
      d   = $urandom_range(1) ? ew / 4 : ew / 7;
      d   = (d == 0) ? 1 : d;
      col = d * int'($urandom_range(8)) + int'($urandom_range(2)) - 1;
      d   = (eh / 2 == 0) ? 1 : eh / 2;
      row = d * int'($urandom_range(2)) + int'($urandom_range(2)) - 1;
    end else begin
      col = $urandom_range(ew - 1);
      row = $urandom_range(eh - 1);
    end
    col = (col < 0) ? 0 : (col > 4095) ? 4095 : col;
    row = (row < 0) ? 0 : (row > 4095) ? 4095 : row;
    send_pixel(col, row);
  endtask

  task automatic run_frame(input logic pat, input int w, input int h,
                           input bit poke_unused, input bit steady);
    load_frame(pat, w, h, poke_unused);
    no_stall <= steady;
    repeat (52) send_random_pixel(w, h);
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset geometry, gradient: 640x640 -> n = 160, m = 320.
    // Interval edges for red/blue, green peak and fall, both outside edges,
    // and all-ones coordinates.
    send_pixel(0, 0);
    send_pixel(159, 1);
    send_pixel(160, 319);
    send_pixel(161, 320);
    send_pixel(320, 321);
    send_pixel(321, 500);
    send_pixel(480, 639);
    send_pixel(481, 2);
    send_pixel(639, 638);
    send_pixel(640, 0);
    send_pixel(0, 640);
    send_pixel(4095, 4095);

    // Same geometry as color bars: bar width 91, bar 8 from column 637 is white.
    load_frame(PAT_BARS, 640, 640, 1'b0);
    send_pixel(0, 0);
    send_pixel(90, 7);
    send_pixel(91, 7);
    send_pixel(182, 100);
    send_pixel(273, 200);
    send_pixel(364, 300);
    send_pixel(455, 400);
    send_pixel(546, 500);
    send_pixel(636, 600);
    send_pixel(637, 639);
    send_pixel(639, 0);

    // Random frames: smallest legal, largest, saturating oversize, frames
    // below the legal range (zero-length intervals), odd shapes.
    run_frame(PAT_GRADIENT, 8, 2, 1'b0, 1'b0);
    run_frame(PAT_BARS, 8, 2, 1'b1, 1'b0);
    run_frame(PAT_GRADIENT, 4096, 4096, 1'b0, 1'b0);
    run_frame(PAT_BARS, 4096, 4096, 1'b0, 1'b1);
    run_frame(PAT_BARS, 8191, 8191, 1'b0, 1'b0);
    run_frame(PAT_GRADIENT, 5000, 3, 1'b0, 1'b0);
    run_frame(PAT_BARS, 640, 480, 1'b1, 1'b0);
    run_frame(PAT_GRADIENT, 3, 1, 1'b0, 1'b0);
    run_frame(PAT_BARS, 6, 0, 1'b0, 1'b0);
    run_frame(PAT_GRADIENT, 1920, 1080, 1'b0, 1'b0);
    run_frame(PAT_BARS, 1366, 768, 1'b0, 1'b0);

    no_stall <= 1'b0;
    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("color_bar_pattern_generator_top verification clean");
    end else begin
      $display("color_bar_pattern_generator_top verification failed");
    end
    $finish;
  end

  // hang guard, far above the slowest legal run
  initial begin
    #2_000_000;
    $display("color_bar_pattern_generator_top verification failed");
    $finish;
  end

endmodule
